// ----- rtl/core/tcw_pkg.sv -----
`default_nettype none

package tcw_pkg;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;

    localparam logic [7:0] REG_TEXT_ATTR  = 8'd0;
    localparam logic [7:0] REG_CLEAR_ATTR = 8'd1;

    localparam logic [7:0] TEXT_ATTR_RESET  = 8'h0F;
    localparam logic [7:0] CLEAR_ATTR_RESET = 8'h07;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [15:0] cell_value;
        logic        screen_cleared;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/tcw_cell_store.sv -----
`default_nettype none

module tcw_cell_store #(
    parameter int DEPTH = 2000
) (
    input  wire                       aclk,
    input  wire                       wr_en,
    input  wire                       rd_en,
    input  wire [$clog2(DEPTH)-1:0]   addr,
    input  wire [15:0]                wr_data,
    output logic [15:0]               rd_data
);

    logic [15:0] mem_reg [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tcw_sequencer.sv -----
`default_nettype none

module tcw_sequencer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire [1:0]                             s_operation,
    input  wire [7:0]                             s_char_code,
    input  wire [10:0]                            s_cell_index,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output tcw_pkg::result_t                      m_result,
    input  wire [7:0]                             text_attr,
    input  wire [7:0]                             clear_attr,
    output logic                                  mem_wr_en,
    output logic                                  mem_rd_en,
    output logic [$clog2(ROWS*COLUMNS)-1:0]       mem_addr,
    output logic [15:0]                           mem_wr_data,
    input  wire [15:0]                            mem_rd_data
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS);

    localparam logic [1:0] ST_SWEEP = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [7:0]        sweep_attr_reg, sweep_attr_next;
    logic              m_valid_reg, m_valid_next;
    tcw_pkg::result_t  result_reg, result_next;

    logic              accept;
    logic [ROW_W:0]    row_inc;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_step;
    logic [COL_W:0]    col_step;
    logic [COL_W-1:0]  put_col;
    logic              put_wr;
    logic              overflow;
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] put_addr;
    logic              in_range;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign row_inc  = (ROW_W + 1)'(row_reg) + (ROW_W + 1)'(1);
    assign col_inc  = (COL_W + 1)'(col_reg) + (COL_W + 1)'(1);
    assign in_range = (32'(s_cell_index) < 32'(CELL_COUNT));

    always_comb begin
        row_step = (ROW_W + 1)'(row_reg);
        col_step = (COL_W + 1)'(col_reg);
        put_col  = col_reg;
        put_wr   = 1'b0;
        case (s_char_code)
            tcw_pkg::CHAR_NEWLINE: begin
                col_step = '0;
                row_step = row_inc;
            end
            tcw_pkg::CHAR_BACKSPACE: begin
                if (col_reg != '0) begin
                    put_col  = col_reg - COL_W'(1);
                    col_step = (COL_W + 1)'(put_col);
                    put_wr   = 1'b1;
                end
            end
            default: begin
                put_wr   = 1'b1;
                col_step = col_inc;
            end
        endcase
        if (col_step == (COL_W + 1)'(COLUMNS)) begin
            col_step = '0;
            row_step = row_inc;
        end
        overflow = (row_step == (ROW_W + 1)'(ROWS));
    end

    assign base_addr = ADDR_W'(row_reg) * ADDR_W'(COLUMNS);
    assign put_addr  = base_addr + ADDR_W'(put_col);

    always_comb begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_attr_next = sweep_attr_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        result_next     = result_reg;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;
        mem_addr        = sweep_addr_reg;
        mem_wr_data     = {sweep_attr_reg, tcw_pkg::CHAR_SPACE};

        case (state_reg)
            ST_SWEEP: begin
                mem_wr_en = 1'b1;
                if (sweep_addr_reg == ADDR_W'(CELL_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    result_next.cell_value     = '0;
                    result_next.screen_cleared = 1'b0;
                    case (s_operation)
                        tcw_pkg::OP_PUT: begin
                            if (overflow) begin
                                row_next                   = '0;
                                col_next                   = '0;
                                sweep_addr_next            = '0;
                                sweep_attr_next            = clear_attr;
                                state_next                 = ST_SWEEP;
                                result_next.screen_cleared = 1'b1;
                            end else begin
                                row_next    = row_step[ROW_W-1:0];
                                col_next    = col_step[COL_W-1:0];
                                mem_wr_en   = put_wr;
                                mem_addr    = put_addr;
                                mem_wr_data = {text_attr,
                                    (s_char_code == tcw_pkg::CHAR_BACKSPACE) ?
                                    tcw_pkg::CHAR_SPACE : s_char_code};
                            end
                        end
                        tcw_pkg::OP_CLEAR: begin
                            row_next                   = '0;
                            col_next                   = '0;
                            sweep_addr_next            = '0;
                            sweep_attr_next            = clear_attr;
                            state_next                 = ST_SWEEP;
                            result_next.screen_cleared = 1'b1;
                        end
                        tcw_pkg::OP_READ: begin
                            if (in_range) begin
                                mem_rd_en  = 1'b1;
                                mem_addr   = ADDR_W'(s_cell_index);
                                state_next = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                    result_next.cursor_row = 5'(row_next);
                    result_next.cursor_col = 7'(col_next);
                    m_valid_next           = (state_next != ST_READ);
                end
            end
            ST_READ: begin
                result_next.cell_value = mem_rd_data;
                m_valid_next           = 1'b1;
                state_next             = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            row_reg        <= '0;
            col_reg        <= '0;
            sweep_addr_reg <= '0;
            sweep_attr_reg <= tcw_pkg::CLEAR_ATTR_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_attr_reg <= sweep_attr_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && result_next.screen_cleared |=> state_reg == ST_SWEEP && sweep_addr_reg == '0)
        else $error("Clearing item did not start a sweep from cell zero.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> !m_valid_reg)
        else $error("Read data returned while the result slot was occupied.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SWEEP |-> row_reg == '0 && col_reg == '0)
        else $error("Cursor left home during a sweep.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (COL_W + 1)'(col_reg) < (COL_W + 1)'(COLUMNS) &&
        (ROW_W + 1)'(row_reg) < (ROW_W + 1)'(ROWS))
        else $error("Cursor outside the screen.");

endmodule

`default_nettype wire

// ----- rtl/core/text_console_writer.sv -----
// Text console writer: a ROWS x COLUMNS screen of 16-bit cells (attribute
// byte over character byte) with a cursor, held in one synchronous RAM.
// The s_ channel takes one beat per item: put character, clear screen or
// read one cell. Each item yields exactly one beat on the m_ channel with
// the cursor after the item, the cell read and a screen-cleared flag.
// A put, a clear, an ignored code and an out-of-range read finish in the
// accepting cycle, so a result appears in the cycle after acceptance and
// puts can stream at one per cycle while the m_ channel is not stalled. A
// read in range passes through the READ state, where the registered output
// of the cell RAM is taken into the result. A clear, or a put that runs
// past the last row, returns its result at once and then sweeps the RAM one
// cell per cycle; s_ready stays low during the sweep.
// After reset the same sweep fills every cell with a blank of attribute
// 0x07, so the block takes no item until the sweep is done. The cfg
// channel is always ready and writes the text attribute (index 0) or the
// clear attribute (index 1); other indexes are ignored.
// A stalled m_ channel holds its beat, and s_ready stays low until the
// pending result is taken or is taken in the same cycle.
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire [1:0]   s_operation,
    input  wire [7:0]   s_char_code,
    input  wire [10:0]  s_cell_index,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [4:0]  m_cursor_row,
    output logic [6:0]  m_cursor_col,
    output logic [15:0] m_cell_value,
    output logic        m_screen_cleared,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [7:0]   cfg_index,
    input  wire [7:0]   cfg_data
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    logic [7:0]        text_attr_reg;
    logic [7:0]        clear_attr_reg;
    tcw_pkg::result_t  result;
    logic              mem_wr_en;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_addr;
    logic [15:0]       mem_wr_data;
    logic [15:0]       mem_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_attr_reg  <= tcw_pkg::TEXT_ATTR_RESET;
            clear_attr_reg <= tcw_pkg::CLEAR_ATTR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tcw_pkg::REG_TEXT_ATTR:  text_attr_reg  <= cfg_data;
                tcw_pkg::REG_CLEAR_ATTR: clear_attr_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    tcw_sequencer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_sequencer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_char_code  (s_char_code),
        .s_cell_index (s_cell_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_result     (result),
        .text_attr    (text_attr_reg),
        .clear_attr   (clear_attr_reg),
        .mem_wr_en    (mem_wr_en),
        .mem_rd_en    (mem_rd_en),
        .mem_addr     (mem_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_data  (mem_rd_data)
    );

    tcw_cell_store #(
        .DEPTH (CELL_COUNT)
    ) u_cell_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .rd_en   (mem_rd_en),
        .addr    (mem_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    assign m_cursor_row     = result.cursor_row;
    assign m_cursor_col     = result.cursor_col;
    assign m_cell_value     = result.cell_value;
    assign m_screen_cleared = result.screen_cleared;

endmodule

`default_nettype wire
